[design/mcvd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI channel voice decoder package
// Command codes, queue sizing and MIDI constants shared by the decoder parts.
// ----------------------------------------------------------------------------
package mcvd_pkg;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CTRL     = 4'hB;
	localparam logic [3:0] ST_PRESSURE = 4'hD;
	localparam logic [3:0] ST_BEND     = 4'hE;

	localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
	localparam logic [6:0] CC_EXPRESSION = 7'd11;
	localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
	localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
	localparam logic [6:0] CC_RPN_LSB    = 7'd100;
	localparam logic [6:0] CC_RPN_MSB    = 7'd101;

	localparam logic [6:0]  BEND_RANGE_RESET = 7'd2;
	localparam logic [14:0] BEND_CENTER      = 15'd8192;

	typedef enum logic [3:0] {
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_BEND,
		OP_PRESSURE,
		OP_DATA_ENTRY,
		OP_EXPR,
		OP_MSB_SET,
		OP_MSB_CLR,
		OP_LSB_SET,
		OP_LSB_CLR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] channel;
		logic [6:0] d1;
		logic [6:0] d2;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[design/mcvd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI channel voice decoder channels
// Valid/ready channels for the incoming byte stream and the voice results.
// ----------------------------------------------------------------------------
interface mcvd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface mcvd_voice_if;
	logic               valid;
	logic               ready;
	logic [3:0]         channel;
	logic               note_attack;
	logic signed [21:0] pitch_q13;
	logic [6:0]         volume;
	logic [6:0]         expr_controller;
	logic [6:0]         expr_value;

	modport source (output valid, output channel, output note_attack, output pitch_q13,
		output volume, output expr_controller, output expr_value, input ready);
	modport sink (input valid, input channel, input note_attack, input pitch_q13,
		input volume, input expr_controller, input expr_value, output ready);
endinterface

[design/mcvd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI decoder front end
// Tracks running status, gathers data bytes and queues decoded commands.
// ----------------------------------------------------------------------------
module mcvd_front import mcvd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic [7:0]    byte_in,
	output logic          ready,
	input  q_stat_t       q_stat,
	output q_wr_t         q_wr
);

	logic [3:0] status_q;
	logic [3:0] channel_q;
	logic       phase_q;
	logic [6:0] first_q;
	logic       accept;
	logic [6:0] d;
	logic       two_byte;

	assign ready    = !q_stat.full;
	assign accept   = valid && ready;
	assign d        = byte_in[6:0];
	assign two_byte = (status_q == ST_NOTE_ON) || (status_q == ST_NOTE_OFF) ||
	                  (status_q == ST_BEND) || (status_q == ST_CTRL);

	always_comb begin
		q_wr.push        = 1'b0;
		q_wr.cmd.op      = OP_NOTE_ON;
		q_wr.cmd.channel = channel_q;
		q_wr.cmd.d1      = first_q;
		q_wr.cmd.d2      = d;
		if (accept && !byte_in[7]) begin
			if (status_q == ST_PRESSURE) begin
				q_wr.push   = 1'b1;
				q_wr.cmd.op = OP_PRESSURE;
			end else if (two_byte && phase_q) begin
				case (status_q)
					ST_NOTE_ON: begin
						q_wr.push   = 1'b1;
						q_wr.cmd.op = OP_NOTE_ON;
					end
					ST_NOTE_OFF: begin
						q_wr.push   = 1'b1;
						q_wr.cmd.op = OP_NOTE_OFF;
					end
					ST_BEND: begin
						q_wr.push   = 1'b1;
						q_wr.cmd.op = OP_BEND;
					end
					default: begin
						q_wr.push = 1'b1;
						case (first_q)
							CC_RPN_MSB:    q_wr.cmd.op = OP_MSB_SET;
							CC_NRPN_MSB:   q_wr.cmd.op = OP_MSB_CLR;
							CC_RPN_LSB:    q_wr.cmd.op = OP_LSB_SET;
							CC_NRPN_LSB:   q_wr.cmd.op = OP_LSB_CLR;
							CC_DATA_ENTRY: q_wr.cmd.op = OP_DATA_ENTRY;
							CC_EXPRESSION: q_wr.cmd.op = OP_EXPR;
							default:       q_wr.push   = 1'b0;
						endcase
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			channel_q <= '0;
			phase_q   <= 1'b0;
			first_q   <= '0;
		end else if (accept) begin
			if (byte_in[7]) begin
				status_q  <= byte_in[7:4];
				channel_q <= byte_in[3:0];
				phase_q   <= 1'b0;
			end else if (two_byte && status_q != ST_PRESSURE && !phase_q) begin
				first_q <= d;
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
			end
		end
	end

	a_pressure_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !byte_in[7] && status_q == ST_PRESSURE) |-> q_wr.push)
		else $error("pressure data byte did not queue a command");

	a_status_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_in[7]) |=> !phase_q)
		else $error("status byte left a partial message pending");

endmodule

[design/mcvd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI decoder command queue
// Small register FIFO that decouples the byte parser from the voice engine.
// ----------------------------------------------------------------------------
module mcvd_queue import mcvd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_wr_t   q_wr,
	input  logic    pop,
	output q_stat_t q_stat,
	output cmd_t    rd_cmd
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign rd_cmd       = mem_q[rd_ptr_q];
	assign do_push      = q_wr.push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_stat.full)
		else $error("command pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

[design/mcvd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI decoder voice engine
// Applies queued commands to the voice state and registers the results.
// ----------------------------------------------------------------------------
module mcvd_back import mcvd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_stat_t  q_stat,
	input  cmd_t     cmd,
	output logic     pop,
	output logic               valid,
	input  logic               ready,
	output logic [3:0]         channel,
	output logic               note_attack,
	output logic signed [21:0] pitch_q13,
	output logic [6:0]         volume,
	output logic [6:0]         expr_controller,
	output logic [6:0]         expr_value
);

	logic [6:0]         note_q;
	logic [6:0]         volume_q;
	logic [13:0]        bend_q;
	logic [6:0]         range_q;
	logic               msb_sel_q;
	logic               lsb_sel_q;
	logic [6:0]         expr_ctl_q;
	logic [6:0]         expr_lvl_q;
	logic signed [21:0] pitch_q;
	logic               out_valid_q;

	logic [6:0]         note_n;
	logic [6:0]         volume_n;
	logic [13:0]        bend_n;
	logic [6:0]         range_n;
	logic               msb_sel_n;
	logic               lsb_sel_n;
	logic [6:0]         expr_ctl_n;
	logic [6:0]         expr_lvl_n;
	logic signed [21:0] pitch_n;
	logic               emit;
	logic               attack;
	logic               recompute;

	logic signed [14:0] bend_off;
	logic signed [22:0] bend_prod;
	logic signed [23:0] pitch_sum;

	assign pop = !q_stat.empty && (!out_valid_q || ready);

	assign bend_off  = $signed({1'b0, bend_n}) - $signed(BEND_CENTER);
	assign bend_prod = $signed({1'b0, range_q}) * bend_off;
	assign pitch_sum = $signed({4'b0, note_n, 13'b0}) + 24'(bend_prod);

	always_comb begin
		note_n     = note_q;
		volume_n   = volume_q;
		bend_n     = bend_q;
		range_n    = range_q;
		msb_sel_n  = msb_sel_q;
		lsb_sel_n  = lsb_sel_q;
		expr_ctl_n = expr_ctl_q;
		expr_lvl_n = expr_lvl_q;
		emit       = 1'b0;
		attack     = 1'b0;
		recompute  = 1'b0;
		case (cmd.op)
			OP_NOTE_ON: begin
				note_n    = cmd.d1;
				volume_n  = cmd.d2;
				recompute = 1'b1;
				emit      = 1'b1;
				attack    = (cmd.d2 != '0);
			end
			OP_NOTE_OFF: begin
				note_n   = cmd.d1;
				volume_n = '0;
				emit     = 1'b1;
			end
			OP_BEND: begin
				bend_n    = {cmd.d2, cmd.d1};
				recompute = 1'b1;
				emit      = 1'b1;
			end
			OP_PRESSURE: begin
				volume_n = cmd.d2;
				emit     = 1'b1;
			end
			OP_DATA_ENTRY: begin
				if (msb_sel_q && lsb_sel_q) begin
					range_n = cmd.d2;
				end
				emit = 1'b1;
			end
			OP_EXPR: begin
				expr_ctl_n = CC_EXPRESSION;
				expr_lvl_n = cmd.d2;
				emit       = 1'b1;
			end
			OP_MSB_SET: msb_sel_n = 1'b1;
			OP_MSB_CLR: msb_sel_n = 1'b0;
			OP_LSB_SET: lsb_sel_n = 1'b1;
			OP_LSB_CLR: lsb_sel_n = 1'b0;
			default: begin
				emit = 1'b0;
			end
		endcase
		pitch_n = recompute ? pitch_sum[21:0] : pitch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q      <= '0;
			volume_q    <= '0;
			bend_q      <= '0;
			range_q     <= BEND_RANGE_RESET;
			msb_sel_q   <= 1'b0;
			lsb_sel_q   <= 1'b0;
			expr_ctl_q  <= '0;
			expr_lvl_q  <= '0;
			pitch_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				note_q     <= note_n;
				volume_q   <= volume_n;
				bend_q     <= bend_n;
				range_q    <= range_n;
				msb_sel_q  <= msb_sel_n;
				lsb_sel_q  <= lsb_sel_n;
				expr_ctl_q <= expr_ctl_n;
				expr_lvl_q <= expr_lvl_n;
				pitch_q    <= pitch_n;
				out_valid_q <= emit;
			end else if (ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			channel         <= cmd.channel;
			note_attack     <= attack;
			pitch_q13       <= pitch_n;
			volume          <= volume_n;
			expr_controller <= expr_ctl_n;
			expr_value      <= expr_lvl_n;
		end
	end

	assign valid = out_valid_q;

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (valid && pitch_q13 == pitch_q && volume == volume_q))
		else $error("result register does not match the updated voice state");

endmodule

[design/midi_channel_voice_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI channel voice decoder
// Decodes running-status MIDI bytes into channel voice results.
// ----------------------------------------------------------------------------
// Bytes arrive on byte_ch, one request per byte; bit 7 marks a status byte.
// Status bytes and incomplete messages give no result. Each completed note
// on, note off, pitch bend, channel pressure, data entry or expression
// message gives one result on voice_ch: channel, attack flag, Q13 pitch,
// volume and the last expression update.
// The front end takes one byte per cycle while the queue has room and queues
// commands in a two-entry queue; the voice engine applies one command per
// cycle unless a result waits on voice_ch, with a single 7 x 15 bit multiply
// for the pitch. A result passes through the queue and the result register,
// and the sustained rate is one byte per cycle while voice_ch takes results.
// When voice_ch stalls, the result register holds, the queue fills and
// byte_ch ready drops once the queue is full; nothing is lost.
// Reset clears the running status, the voice state and all pending work;
// the bend range comes up at two semitones.
// ----------------------------------------------------------------------------
module midi_channel_voice_decoder_top import mcvd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mcvd_byte_if.sink    byte_ch,
	mcvd_voice_if.source voice_ch
);

	q_wr_t   q_wr;
	q_stat_t q_stat;
	cmd_t    rd_cmd;
	logic    pop;

	mcvd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (byte_ch.valid),
		.byte_in (byte_ch.byte_in),
		.ready   (byte_ch.ready),
		.q_stat  (q_stat),
		.q_wr    (q_wr)
	);

	mcvd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_stat (q_stat),
		.rd_cmd (rd_cmd)
	);

	mcvd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.cmd             (rd_cmd),
		.pop             (pop),
		.valid           (voice_ch.valid),
		.ready           (voice_ch.ready),
		.channel         (voice_ch.channel),
		.note_attack     (voice_ch.note_attack),
		.pitch_q13       (voice_ch.pitch_q13),
		.volume          (voice_ch.volume),
		.expr_controller (voice_ch.expr_controller),
		.expr_value      (voice_ch.expr_value)
	);

endmodule

[tb/tb_midi_channel_voice_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI channel voice decoder testbench
// Streams MIDI bytes into the decoder with running status, aborted and
// unknown messages, RPN bend range updates and random idling on both
// channels. It predicts every voice result from its own copy of the voice
// state and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_midi_channel_voice_decoder_top import mcvd_pkg::*; ();

	localparam int         CLK_HALF          = 5;
	localparam int         CYCLE_LIMIT       = 250000;
	localparam int         Q13_ONE           = 8192;
	localparam int         MAX_PRINTED       = 50;
	localparam logic [3:0] ST_POLY_PRESSURE  = 4'hA;
	localparam logic [3:0] ST_PROGRAM        = 4'hC;
	localparam logic [3:0] ST_SYSTEM         = 4'hF;
	localparam logic [6:0] CC_DATA_ENTRY_LSB = 7'd38;
	localparam logic [7:0] RT_TIMING_CLOCK   = 8'hF8;

	typedef struct packed {
		logic [3:0]  channel;
		logic        attack;
		logic [21:0] pitch;
		logic [6:0]  volume;
		logic [6:0]  expr_ctl;
		logic [6:0]  expr_val;
	} voice_t;

	logic clk;
	logic arst_n;

	mcvd_byte_if  byte_bus();
	mcvd_voice_if voice_bus();

	midi_channel_voice_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_bus),
		.voice_ch (voice_bus)
	);

	logic [3:0]  run_status;
	logic [3:0]  run_chan;
	logic        awaiting_second;
	logic [6:0]  held_first;
	logic [6:0]  note_num;
	logic [6:0]  vol_level;
	logic [13:0] bend_val;
	logic [6:0]  bend_range;
	logic        rpn_msb;
	logic        rpn_lsb;
	logic [6:0]  expr_ctl_now;
	logic [6:0]  expr_val_now;
	logic [21:0] pitch_now;

	voice_t expected_voices[$];

	int bytes_sent         = 0;
	int results_checked    = 0;
	int attacks_seen       = 0;
	int error_count        = 0;
	int cycle_count        = 0;
	int input_stall_cycles = 0;
	int rx_hold_request    = 0;
	bit tx_gaps_on         = 0;
	bit rx_stalls_on       = 0;
	bit force_status       = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void reset_voice_state();
		run_status      = '0;
		run_chan        = '0;
		awaiting_second = 1'b0;
		held_first      = '0;
		note_num        = '0;
		vol_level       = '0;
		bend_val        = '0;
		bend_range      = BEND_RANGE_RESET;
		rpn_msb         = 1'b0;
		rpn_lsb         = 1'b0;
		expr_ctl_now    = '0;
		expr_val_now    = '0;
		pitch_now       = '0;
	endfunction

	function automatic void recalc_pitch();
		int p;
		p = int'(note_num) * Q13_ONE
			+ int'(bend_range) * (int'(bend_val) - int'(BEND_CENTER));
		pitch_now = p[21:0];
	endfunction

	function automatic bit decode_midi_byte(input logic [7:0] b, output voice_t v);
		logic [6:0] d;
		bit emit;
		bit attack;
		d      = b[6:0];
		emit   = 1'b0;
		attack = 1'b0;
		v      = '0;
		if (b[7]) begin
			run_status      = b[7:4];
			run_chan        = b[3:0];
			awaiting_second = 1'b0;
			return 1'b0;
		end
		if (run_status == ST_PRESSURE) begin
			vol_level       = d;
			awaiting_second = 1'b0;
			emit            = 1'b1;
		end else if (!(run_status inside {ST_NOTE_ON, ST_NOTE_OFF, ST_BEND, ST_CTRL})) begin
			awaiting_second = 1'b0;
		end else if (!awaiting_second) begin
			held_first      = d;
			awaiting_second = 1'b1;
		end else begin
			awaiting_second = 1'b0;
			case (run_status)
				ST_NOTE_ON: begin
					note_num  = held_first;
					vol_level = d;
					recalc_pitch();
					emit      = 1'b1;
					attack    = (d != 7'd0);
				end
				ST_NOTE_OFF: begin
					note_num  = held_first;
					vol_level = '0;
					emit      = 1'b1;
				end
				ST_BEND: begin
					bend_val = {d, held_first};
					recalc_pitch();
					emit     = 1'b1;
				end
				default: begin
					if (held_first == CC_NRPN_MSB || held_first == CC_RPN_MSB) begin
						rpn_msb = (held_first == CC_RPN_MSB);
					end else if (held_first == CC_NRPN_LSB || held_first == CC_RPN_LSB) begin
						rpn_lsb = (held_first == CC_RPN_LSB);
					end else if (held_first == CC_DATA_ENTRY) begin
						if (rpn_msb && rpn_lsb)
							bend_range = d;
						emit = 1'b1;
					end else if (held_first == CC_EXPRESSION) begin
						expr_ctl_now = CC_EXPRESSION;
						expr_val_now = d;
						emit         = 1'b1;
					end
				end
			endcase
		end
		v.channel  = run_chan;
		v.attack   = attack;
		v.pitch    = pitch_now;
		v.volume   = vol_level;
		v.expr_ctl = expr_ctl_now;
		v.expr_val = expr_val_now;
		return emit;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		voice_t v;
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			byte_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		byte_bus.valid   <= 1'b1;
		byte_bus.byte_in <= b;
		do @(posedge clk); while (!byte_bus.ready);
		bytes_sent++;
		if (decode_midi_byte(b, v))
			expected_voices.push_back(v);
	endtask

	task automatic send_status(input logic [3:0] st, input logic [3:0] ch);
		send_byte({st, ch});
	endtask

	task automatic send_data(input logic [6:0] d);
		send_byte({1'b0, d});
	endtask

	task automatic drain_results();
		byte_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_voices.size() != 0);
	endtask

	function automatic logic [6:0] rand_data7();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [3:0] rand_voice_status();
		case ($urandom_range(0, 4))
			0: return ST_NOTE_ON;
			1: return ST_NOTE_OFF;
			2: return ST_BEND;
			3: return ST_PRESSURE;
			default: return ST_CTRL;
		endcase
	endfunction

	task automatic send_voice_msg(input logic [3:0] st, input logic [6:0] d1,
		input logic [6:0] d2);
		if (force_status || run_status != st || $urandom_range(0, 2) == 0)
			send_status(st, 4'($urandom_range(0, 15)));
		force_status = 1'b0;
		send_data(d1);
		if (st != ST_PRESSURE)
			send_data(d2);
	endtask

	task automatic send_random_message();
		int pick;
		logic [6:0] ctl;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 12) begin
			send_status(rand_voice_status(), 4'($urandom_range(0, 15)));
			send_data(rand_data7());
			if ($urandom_range(0, 1))
				send_byte(RT_TIMING_CLOCK);
			force_status = 1'b1;
		end else if (pick < 20) begin
			case ($urandom_range(0, 2))
				0: send_status(ST_POLY_PRESSURE, 4'($urandom_range(0, 15)));
				1: send_status(ST_PROGRAM, 4'($urandom_range(0, 15)));
				default: send_status(ST_SYSTEM, 4'($urandom_range(0, 15)));
			endcase
			repeat ($urandom_range(1, 3)) send_data(rand_data7());
			force_status = 1'b1;
		end else if (pick < 52) begin
			send_voice_msg(ST_NOTE_ON, rand_data7(), rand_data7());
		end else if (pick < 62) begin
			send_voice_msg(ST_NOTE_OFF, rand_data7(), rand_data7());
		end else if (pick < 74) begin
			send_voice_msg(ST_BEND, rand_data7(), rand_data7());
		end else if (pick < 80) begin
			send_voice_msg(ST_PRESSURE, rand_data7(), '0);
		end else begin
			case ($urandom_range(0, 9))
				0, 1: ctl = CC_DATA_ENTRY;
				2, 3: ctl = CC_EXPRESSION;
				4: ctl = $urandom_range(0, 1) ? CC_RPN_MSB : CC_NRPN_MSB;
				5: ctl = $urandom_range(0, 1) ? CC_RPN_LSB : CC_NRPN_LSB;
				6: ctl = CC_DATA_ENTRY_LSB;
				7: ctl = 7'($urandom_range(0, 127));
				default: begin
					send_voice_msg(ST_CTRL, CC_RPN_MSB, '0);
					send_voice_msg(ST_CTRL, CC_RPN_LSB, '0);
					ctl = CC_DATA_ENTRY;
				end
			endcase
			send_voice_msg(ST_CTRL, ctl, rand_data7());
		end
	endtask

	task automatic test_reset_defaults();
		send_data(7'h45);
		send_data(7'h00);
		send_status(ST_NOTE_ON, 4'd0);
		send_data(7'd0);
		send_data(7'd127);
		send_data(7'd127);
		send_data(7'd0);
		send_status(ST_NOTE_OFF, 4'd15);
		send_data(7'h40);
		send_data(7'h55);
	endtask

	task automatic test_bend_range_extremes();
		send_status(ST_CTRL, 4'd3);
		send_data(CC_DATA_ENTRY);
		send_data(7'd50);
		send_data(CC_RPN_MSB);
		send_data(7'd0);
		send_data(CC_RPN_LSB);
		send_data(7'd0);
		send_data(CC_DATA_ENTRY);
		send_data(7'd127);
		send_data(CC_EXPRESSION);
		send_data(7'd127);
		send_data(CC_DATA_ENTRY_LSB);
		send_data(7'd17);
		send_status(ST_NOTE_ON, 4'd3);
		send_data(7'd127);
		send_data(7'd1);
		send_status(ST_BEND, 4'd3);
		send_data(7'd127);
		send_data(7'd127);
		send_data(7'd0);
		send_data(7'd0);
		send_status(ST_NOTE_ON, 4'd3);
		send_data(7'd0);
		send_data(7'd64);
		send_status(ST_CTRL, 4'd3);
		send_data(CC_NRPN_MSB);
		send_data(7'd0);
		send_data(CC_NRPN_LSB);
		send_data(7'd0);
		send_data(CC_DATA_ENTRY);
		send_data(7'd0);
		send_data(CC_RPN_MSB);
		send_data(7'd0);
		send_data(CC_RPN_LSB);
		send_data(7'd0);
		send_data(CC_DATA_ENTRY);
		send_data(BEND_RANGE_RESET);
	endtask

	task automatic test_abort_and_unknown();
		send_status(ST_PRESSURE, 4'd5);
		send_data(7'd0);
		send_data(7'd127);
		send_status(ST_NOTE_ON, 4'd10);
		send_data(7'h3C);
		send_byte(RT_TIMING_CLOCK);
		send_data(7'h3C);
		send_data(7'h40);
		send_status(ST_POLY_PRESSURE, 4'd0);
		send_data(7'h10);
		send_data(7'h20);
		send_status(ST_PROGRAM, 4'd1);
		send_data(7'h05);
		send_status(ST_BEND, 4'd0);
		send_data(7'h40);
		send_status(ST_NOTE_ON, 4'd2);
		send_data(7'd127);
		send_data(7'd1);
	endtask

	task automatic test_random_messages(input int until_count, input bit with_idling);
		tx_gaps_on   = with_idling;
		rx_stalls_on = with_idling;
		while (bytes_sent < until_count)
			send_random_message();
	endtask

	task automatic test_result_backpressure();
		tx_gaps_on      = 1'b0;
		rx_hold_request = 300;
		repeat (30) send_voice_msg(ST_NOTE_ON, rand_data7(), rand_data7());
		drain_results();
	endtask

	initial begin : voice_receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		voice_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				voice_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				voice_bus.ready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 14);
				voice_bus.ready <= 1'b0;
			end else begin
				voice_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		voice_t want;
		if (arst_n && byte_bus.valid && !byte_bus.ready)
			input_stall_cycles++;
		if (arst_n && voice_bus.valid && voice_bus.ready) begin
			if (expected_voices.size() == 0) begin
				report_mismatch($sformatf("unexpected voice result on channel %0d",
					voice_bus.channel));
			end else begin
				want = expected_voices.pop_front();
				if (voice_bus.channel !== want.channel)
					report_mismatch($sformatf("result %0d channel: got %0d, expected %0d",
						results_checked, voice_bus.channel, want.channel));
				if (voice_bus.note_attack !== want.attack)
					report_mismatch($sformatf("result %0d note_attack: got %0b, expected %0b",
						results_checked, voice_bus.note_attack, want.attack));
				if (voice_bus.pitch_q13 !== want.pitch)
					report_mismatch($sformatf("result %0d pitch_q13: got %0d, expected %0d",
						results_checked, $signed(voice_bus.pitch_q13), $signed(want.pitch)));
				if (voice_bus.volume !== want.volume)
					report_mismatch($sformatf("result %0d volume: got %0d, expected %0d",
						results_checked, voice_bus.volume, want.volume));
				if (voice_bus.expr_controller !== want.expr_ctl)
					report_mismatch($sformatf("result %0d expr_controller: got %0d, expected %0d",
						results_checked, voice_bus.expr_controller, want.expr_ctl));
				if (voice_bus.expr_value !== want.expr_val)
					report_mismatch($sformatf("result %0d expr_value: got %0d, expected %0d",
						results_checked, voice_bus.expr_value, want.expr_val));
				if (want.attack)
					attacks_seen++;
			end
			results_checked++;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
			expected_voices.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		byte_bus.valid   <= 1'b0;
		byte_bus.byte_in <= '0;
		reset_voice_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_bend_range_extremes();
		test_abort_and_unknown();
		test_random_messages(700, 1'b1);
		test_result_backpressure();
		test_random_messages(1050, 1'b1);
		test_random_messages(1350, 1'b0);

		drain_results();
		repeat (20) @(posedge clk);

		$display("Sent %0d MIDI bytes and checked %0d voice results (%0d note attacks).",
			bytes_sent, results_checked, attacks_seen);
		$display("Covered running status, aborted and unknown messages, RPN bend range %s",
			$sformatf("updates and %0d cycles of stalled byte input.", input_stall_cycles));
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/mcvd_pkg.sv
design/mcvd_if.sv
design/mcvd_front.sv
design/mcvd_queue.sv
design/mcvd_back.sv
design/midi_channel_voice_decoder_top.sv
tb/tb_midi_channel_voice_decoder_top.sv
